/* rtl/bev_pkg.sv */
// Shared types, widths and register codes for the button event block.
`timescale 1ns / 1ps

package bev_pkg;

   // Design limits and field widths.
   localparam int NUM_BUTTONS_DEFAULT = 10;
   localparam int MAX_BUTTONS         = 32;
   localparam int LEVEL_SEL_W         = $clog2(MAX_BUTTONS);
   localparam int LEVEL_BITS          = 10;
   localparam int BUTTON_ID_W         = 4;
   localparam int COUNT_W             = 16;
   localparam int PERIOD_W            = 8;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_DELAY    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_PERIOD     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LOW      = 3'd4;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0]  REPEAT_DELAY_RESET    = 16'd1;
   localparam logic [COUNT_W-1:0]  REPEAT_INTERVAL_RESET = 16'd0;
   localparam logic [PERIOD_W-1:0] POLL_PERIOD_RESET     = 8'd10;

   // Event kind codes.
   localparam logic EVENT_PRESSED  = 1'b0;
   localparam logic EVENT_RELEASED = 1'b1;

   // Configuration as seen by the scanner.
   typedef struct packed {
      logic                repeat_enable;
      logic [COUNT_W-1:0]  repeat_delay_ms;
      logic [COUNT_W-1:0]  repeat_interval_ms;
      logic [PERIOD_W-1:0] poll_period_ms;
      logic                active_low;
   } cfg_type;

   // One entry of the per-button state memory.
   typedef struct packed {
      logic               pressed;
      logic [COUNT_W-1:0] countdown;
   } entry_type;

endpackage

/* rtl/bev_state_ram.sv */
// Per-button state memory with registered read and reset valid bits.
`timescale 1ns / 1ps

module bev_state_ram #(
   parameter int Depth = bev_pkg::NUM_BUTTONS_DEFAULT,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [AddrW-1:0]    rd_addr,
   output bev_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AddrW-1:0]    wr_addr,
   input  bev_pkg::entry_type  wr_data
);

   bev_pkg::entry_type mem [Depth];
   bev_pkg::entry_type rd_data_ff;
   logic               rd_valid_ff;
   logic [Depth-1:0]   valid_ff;

   // Valid bits mark entries written since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // An entry never written since reset reads as all zero.
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* rtl/bev_scan.sv */
// Button scanner: reads each button's state, evaluates edges and repeats, emits events.
`timescale 1ns / 1ps

module bev_scan #(
   parameter int NumButtons = bev_pkg::NUM_BUTTONS_DEFAULT,
   parameter int IdxW       = (NumButtons > 1) ? $clog2(NumButtons) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bev_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bev_pkg::LEVEL_BITS-1:0]      req_raw_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bev_pkg::BUTTON_ID_W-1:0]     rsp_button_id,
   output logic                                rsp_event_kind,
   output logic                                rsp_last_of_tick,
   output logic [IdxW-1:0]                     ram_rd_addr,
   input  bev_pkg::entry_type                  ram_rd_data,
   output logic                                ram_wr_en,
   output logic [IdxW-1:0]                     ram_wr_addr,
   output bev_pkg::entry_type                  ram_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_PUSH,
      S_FLUSH
   } state_type;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(NumButtons - 1);

   state_type                             state_ff, state_in;
   logic [IdxW-1:0]                       idx_ff, idx_in;
   logic [bev_pkg::LEVEL_BITS-1:0]        levels_ff, levels_in;
   logic                                  ev_two_ff, ev_two_in;
   logic                                  ev_kind_ff, ev_kind_in;
   logic                                  hold_valid_ff, hold_valid_in;
   logic [bev_pkg::BUTTON_ID_W-1:0]       hold_id_ff, hold_id_in;
   logic                                  hold_kind_ff, hold_kind_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [bev_pkg::BUTTON_ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                                  rsp_kind_ff, rsp_kind_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic [bev_pkg::MAX_BUTTONS-1:0]       levels_ext;
   logic                                  pressed_now;
   logic [bev_pkg::COUNT_W-1:0]           period_ext;
   bev_pkg::entry_type                    next_entry;
   logic                                  ev_any;
   logic                                  ev_two;
   logic                                  ev_kind;
   logic                                  out_free;
   logic                                  scan_done;

   // Evaluate the current button against its stored state.
   always_comb begin
      levels_ext  = {{(bev_pkg::MAX_BUTTONS - bev_pkg::LEVEL_BITS){1'b0}}, levels_ff};
      pressed_now = levels_ext[bev_pkg::LEVEL_SEL_W'(idx_ff)] ^ cfg.active_low;
      period_ext  = bev_pkg::COUNT_W'(cfg.poll_period_ms);
      next_entry  = ram_rd_data;
      ev_any      = 1'b0;
      ev_two      = 1'b0;
      ev_kind     = bev_pkg::EVENT_PRESSED;
      if (!ram_rd_data.pressed && pressed_now) begin
         next_entry.pressed = 1'b1;
         ev_any             = 1'b1;
         if (cfg.repeat_enable) begin
            next_entry.countdown = cfg.repeat_delay_ms;
         end
      end else if (ram_rd_data.pressed && !pressed_now) begin
         next_entry.pressed = 1'b0;
         ev_any             = 1'b1;
         ev_kind            = bev_pkg::EVENT_RELEASED;
         if (cfg.repeat_enable) begin
            next_entry.countdown = '0;
         end
      end else if (cfg.repeat_enable && (ram_rd_data.countdown != '0) &&
                   (cfg.poll_period_ms != '0)) begin
         if (ram_rd_data.countdown <= period_ext) begin
            // Expired: a released and a pressed event, then reload.
            ev_any               = 1'b1;
            ev_two               = 1'b1;
            ev_kind              = bev_pkg::EVENT_RELEASED;
            next_entry.countdown = cfg.repeat_interval_ms;
         end else begin
            next_entry.countdown = ram_rd_data.countdown - period_ext;
         end
      end
   end

   // Sequencer and event buffering. The newest event waits in a hold stage
   // until a later one arrives or the scan ends, which fixes its last flag.
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      scan_done     = (idx_ff == LastIdx);
      state_in      = state_ff;
      idx_in        = idx_ff;
      levels_in     = levels_ff;
      ev_two_in     = ev_two_ff;
      ev_kind_in    = ev_kind_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in    = hold_id_ff;
      hold_kind_in  = hold_kind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_id_in     = rsp_id_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               levels_in = req_raw_levels;
               idx_in    = '0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            ram_wr_en  = 1'b1;
            ev_two_in  = ev_two;
            ev_kind_in = ev_kind;
            if (ev_any) begin
               state_in = S_PUSH;
            end else if (scan_done) begin
               state_in = S_FLUSH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_PUSH: begin
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = hold_id_ff;
                  rsp_kind_in  = hold_kind_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_id_in    = bev_pkg::BUTTON_ID_W'(idx_ff);
               hold_kind_in  = ev_kind_ff;
               if (ev_two_ff) begin
                  ev_two_in  = 1'b0;
                  ev_kind_in = bev_pkg::EVENT_PRESSED;
               end else if (scan_done) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = hold_id_ff;
               rsp_kind_in   = hold_kind_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      levels_ff    <= levels_in;
      ev_two_ff    <= ev_two_in;
      ev_kind_ff   <= ev_kind_in;
      hold_id_ff   <= hold_id_in;
      hold_kind_ff <= hold_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Memory reads the current button; write-back happens during evaluation.
   assign ram_rd_addr      = idx_ff;
   assign ram_wr_addr      = idx_ff;
   assign ram_wr_data      = next_entry;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_id    = rsp_id_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_last_of_tick = rsp_last_ff;

endmodule

/* rtl/button_edge_events_with_repeat.sv */
// Top level of the button edge event block with auto-repeat.
`timescale 1ns / 1ps

// Usage:
// - req channel: one transfer per poll tick, req_raw_levels bit i is the raw
//   pin level of button i. csr channel: register index and data, always ready;
//   write only while the block is idle.
// - rsp channel: zero or more events per tick, each with button id and kind
//   (0 pressed, 1 released); the final event of a tick has rsp_last_of_tick set.
// - Buttons are scanned in ascending order through a state memory with a
//   registered read: each button passes through a read state and an
//   evaluate/write-back state, plus a push state per event it produces.
//   After the last button a flush state ends the tick, then req_ready
//   returns high.
// - The newest event waits in a hold stage until the next one or the end of
//   the scan decides its last flag; events leave through an output register.
// - A stalled receiver holds the scanner at its next event push; no event is
//   lost, and a tick may be accepted while the previous last event waits.
// - Reset clears the configuration to its defaults and marks every button
//   released with a zero countdown through per-entry valid bits; no clearing
//   pass is needed.
module button_edge_events_with_repeat #(
   parameter int NumButtons = bev_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bev_pkg::LEVEL_BITS-1:0]    req_raw_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bev_pkg::BUTTON_ID_W-1:0]   rsp_button_id,
   output logic                              rsp_event_kind,
   output logic                              rsp_last_of_tick,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bev_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bev_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IdxW = (NumButtons > 1) ? $clog2(NumButtons) : 1;

   bev_pkg::cfg_type   cfg_ff, cfg_in;
   logic [IdxW-1:0]    ram_rd_addr;
   bev_pkg::entry_type ram_rd_data;
   logic               ram_wr_en;
   logic [IdxW-1:0]    ram_wr_addr;
   bev_pkg::entry_type ram_wr_data;

   // Configuration register decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bev_pkg::CSR_REPEAT_ENABLE:   cfg_in.repeat_enable      = csr_data[0];
            bev_pkg::CSR_REPEAT_DELAY:    cfg_in.repeat_delay_ms    = csr_data;
            bev_pkg::CSR_REPEAT_INTERVAL: cfg_in.repeat_interval_ms = csr_data;
            bev_pkg::CSR_POLL_PERIOD:
               cfg_in.poll_period_ms = csr_data[bev_pkg::PERIOD_W-1:0];
            bev_pkg::CSR_ACTIVE_LOW:      cfg_in.active_low         = csr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_enable      <= 1'b0;
         cfg_ff.repeat_delay_ms    <= bev_pkg::REPEAT_DELAY_RESET;
         cfg_ff.repeat_interval_ms <= bev_pkg::REPEAT_INTERVAL_RESET;
         cfg_ff.poll_period_ms     <= bev_pkg::POLL_PERIOD_RESET;
         cfg_ff.active_low         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // Per-button state memory.
   bev_state_ram #(
      .Depth (NumButtons),
      .AddrW (IdxW)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // Scanner and event output.
   bev_scan #(
      .NumButtons (NumButtons),
      .IdxW       (IdxW)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_levels   (req_raw_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_button_id    (rsp_button_id),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_last_of_tick (rsp_last_of_tick),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data)
   );

endmodule

/* rtl/bev_checker.sv */
// Port-level checker for the button event block, bound to the top level.
`timescale 1ns / 1ps

module bev_checker #(
   parameter int NumButtons = bev_pkg::NUM_BUTTONS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [bev_pkg::BUTTON_ID_W-1:0]   rsp_button_id,
   input logic                              rsp_event_kind,
   input logic                              rsp_last_of_tick
);

   // A stalled event holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_button_id) &&
      $stable(rsp_event_kind) && $stable(rsp_last_of_tick))
      else $error("rsp payload changed while stalled");

   // Events name existing buttons only.
   a_rsp_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (NumButtons > 16) ||
      (rsp_button_id <= bev_pkg::BUTTON_ID_W'(NumButtons - 1)))
      else $error("rsp_button_id out of range");

   // While a tick still has events to come, no new tick is taken.
   a_no_tick_midstream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_tick |-> !req_ready)
      else $error("tick accepted before previous tick finished");

   // A tick transfer starts a scan that cannot take another tick next cycle.
   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a tick transfer");

   // Reset leaves no event pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind button_edge_events_with_repeat bev_checker #(
   .NumButtons (NumButtons)
) u_bev_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_button_id    (rsp_button_id),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_last_of_tick (rsp_last_of_tick)
);
